@@ rtl/core/scc_pkg.sv @@
// shared types and constants for the swept circle collision test pipeline
// no dependencies; every rtl/core module refers to this package by scoped names
`default_nettype none

package scc_pkg;

    // fixed point format of positions, velocities, radii and time
    localparam int FRAC_BITS = 16;

    // time of closest approach divider: quotient bits and dividend bits below the
    // initial partial remainder
    localparam int TQ_BITS = 32;
    localparam int TD_LOW  = TQ_BITS - FRAC_BITS;

    // integer square root: one result bit per stage, radicand is twice as wide
    localparam int SQ_STEPS = 32;
    localparam int SQ_IN    = 2 * SQ_STEPS;

    // offset divider (coordinate * radius / distance): quotient bits
    localparam int OQ_BITS = 31;

    // input beat
    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic        [30:0] radius_a;
        logic        [30:0] radius_b;
        logic        [30:0] step_time;
    } t_in;

    // output beat
    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
    } t_out;

    // time divider stage contents
    typedef struct packed {
        logic        [65:0]        vsq;
        logic        [65:0]        rem;
        logic        [TQ_BITS-1:0] dvd;
        logic        [TQ_BITS-1:0] quo;
        logic                      ovf;
        logic                      pos;
        logic signed [32:0]        dx;
        logic signed [32:0]        dy;
        logic signed [32:0]        rvx;
        logic signed [32:0]        rvy;
        logic signed [31:0]        pax;
        logic signed [31:0]        pay;
        logic signed [31:0]        vax;
        logic signed [31:0]        vay;
        logic        [30:0]        ra;
        logic        [30:0]        rb;
        logic        [30:0]        dt;
    } t_tdv;

    // square root stage contents
    typedef struct packed {
        logic        [SQ_IN-1:0]    rad;
        logic        [35:0]         rem;
        logic        [SQ_STEPS-1:0] root;
        logic                       hit;
        logic        [32:0]         mx;
        logic        [32:0]         my;
        logic                       sx;
        logic                       sy;
        logic signed [48:0]         ax;
        logic signed [48:0]         ay;
        logic        [30:0]         ra;
    } t_sqs;

    // offset divider stage contents
    typedef struct packed {
        logic        [31:0]        span;
        logic        [31:0]        remx;
        logic        [31:0]        remy;
        logic        [OQ_BITS-1:0] dvx;
        logic        [OQ_BITS-1:0] dvy;
        logic        [OQ_BITS-1:0] qx;
        logic        [OQ_BITS-1:0] qy;
        logic                      dz;
        logic                      hit;
        logic                      sx;
        logic                      sy;
        logic signed [48:0]        ax;
        logic signed [48:0]        ay;
        logic        [30:0]        ra;
    } t_odv;

endpackage

`default_nettype wire

@@ rtl/core/scc_front.sv @@
// front end: separations, relative velocity, dot products, divider setup
// four register stages; depends on scc_pkg
`default_nettype none

module scc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire scc_pkg::t_in  i_in,
    output logic               o_vld,
    output scc_pkg::t_tdv      o_st
);

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic        [30:0] ra;
        logic        [30:0] rb;
        logic        [30:0] dt;
    } t_s1;

    typedef struct packed {
        logic signed [65:0] pxx;
        logic signed [65:0] pyy;
        logic signed [65:0] pdx;
        logic signed [65:0] pdy;
        t_s1                b;
    } t_s2;

    typedef struct packed {
        logic [65:0] vsq;
        logic [65:0] num;
        logic        pos;
        t_s1         b;
    } t_s3;

    t_s1 r1, n1;
    t_s2 r2, n2;
    t_s3 r3, n3;
    scc_pkg::t_tdv r4, n4;
    logic r1_vld, r2_vld, r3_vld, r4_vld;

    logic signed [66:0] s_dot;
    logic signed [66:0] s_vsq;
    logic signed [66:0] s_neg;

    // stage 1: differences
    always_comb begin
        n1.dx  = 33'(i_in.pos_b_x) - 33'(i_in.pos_a_x);
        n1.dy  = 33'(i_in.pos_b_y) - 33'(i_in.pos_a_y);
        n1.rvx = 33'(i_in.vel_b_x) - 33'(i_in.vel_a_x);
        n1.rvy = 33'(i_in.vel_b_y) - 33'(i_in.vel_a_y);
        n1.pax = i_in.pos_a_x;
        n1.pay = i_in.pos_a_y;
        n1.vax = i_in.vel_a_x;
        n1.vay = i_in.vel_a_y;
        n1.ra  = i_in.radius_a;
        n1.rb  = i_in.radius_b;
        n1.dt  = i_in.step_time;
    end

    // stage 2: products
    always_comb begin
        n2.pxx = 66'(r1.rvx) * 66'(r1.rvx);
        n2.pyy = 66'(r1.rvy) * 66'(r1.rvy);
        n2.pdx = 66'(r1.dx) * 66'(r1.rvx);
        n2.pdy = 66'(r1.dy) * 66'(r1.rvy);
        n2.b   = r1;
    end

    // stage 3: |v|^2 and negated d.v
    always_comb begin
        s_vsq  = 67'(r2.pxx) + 67'(r2.pyy);
        s_dot  = 67'(r2.pdx) + 67'(r2.pdy);
        s_neg  = -s_dot;
        n3.vsq = s_vsq[65:0];
        n3.num = s_neg[65:0];
        n3.pos = s_dot[66];
        n3.b   = r2.b;
    end

    // stage 4: partial remainder, overflow of the quotient range
    always_comb begin
        n4.vsq = r3.vsq;
        n4.rem = r3.num >> scc_pkg::TD_LOW;
        n4.ovf = (r3.num >> scc_pkg::TD_LOW) >= r3.vsq;
        n4.dvd = scc_pkg::TQ_BITS'({r3.num[scc_pkg::TD_LOW-1:0],
                                    {scc_pkg::FRAC_BITS{1'b0}}});
        n4.quo = '0;
        n4.pos = r3.pos;
        n4.dx  = r3.b.dx;
        n4.dy  = r3.b.dy;
        n4.rvx = r3.b.rvx;
        n4.rvy = r3.b.rvy;
        n4.pax = r3.b.pax;
        n4.pay = r3.b.pay;
        n4.vax = r3.b.vax;
        n4.vay = r3.b.vay;
        n4.ra  = r3.b.ra;
        n4.rb  = r3.b.rb;
        n4.dt  = r3.b.dt;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1 <= n1;
            r2 <= n2;
            r3 <= n3;
            r4 <= n4;
        end
    end

    assign o_vld = r4_vld;
    assign o_st  = r4;

endmodule

`default_nettype wire

@@ rtl/core/scc_tdiv.sv @@
// pipelined restoring divider for the time of closest approach, one quotient bit per stage
// depends on scc_pkg
`default_nettype none

module scc_tdiv (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire scc_pkg::t_tdv  i_st,
    output logic                o_vld,
    output scc_pkg::t_tdv       o_st
);

    // one restoring step
    function automatic scc_pkg::t_tdv f_step(scc_pkg::t_tdv s);
        scc_pkg::t_tdv n;
        logic [66:0]   sh;
        n   = s;
        sh  = {s.rem, s.dvd[scc_pkg::TQ_BITS-1]};
        n.dvd = {s.dvd[scc_pkg::TQ_BITS-2:0], 1'b0};
        if (sh >= {1'b0, s.vsq}) begin
            n.rem = 66'(sh - {1'b0, s.vsq});
            n.quo = {s.quo[scc_pkg::TQ_BITS-2:0], 1'b1};
        end else begin
            n.rem = sh[65:0];
            n.quo = {s.quo[scc_pkg::TQ_BITS-2:0], 1'b0};
        end
        return n;
    endfunction

    scc_pkg::t_tdv r_st [scc_pkg::TQ_BITS];
    logic [scc_pkg::TQ_BITS-1:0] r_vld;

    for (genvar k = 0; k < scc_pkg::TQ_BITS; k++) begin : g_stage
        scc_pkg::t_tdv n_st;
        logic          n_vld;

        if (k == 0) begin : g_first
            assign n_st  = f_step(i_st);
            assign n_vld = i_vld;
        end else begin : g_next
            assign n_st  = f_step(r_st[k-1]);
            assign n_vld = r_vld[k-1];
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_vld = r_vld[scc_pkg::TQ_BITS-1];
    assign o_st  = r_st[scc_pkg::TQ_BITS-1];

endmodule

`default_nettype wire

@@ rtl/core/scc_mid.sv @@
// clamp of the approach time, positions at that time, squared distance and hit test
// five register stages; depends on scc_pkg
`default_nettype none

module scc_mid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire scc_pkg::t_tdv  i_st,
    output logic                o_vld,
    output scc_pkg::t_sqs       o_st
);

    typedef struct packed {
        logic        [30:0] t;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic        [30:0] ra;
        logic        [30:0] rb;
    } t_m1;

    typedef struct packed {
        logic signed [64:0] prx;
        logic signed [64:0] pry;
        logic signed [63:0] pvx;
        logic signed [63:0] pvy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic        [30:0] ra;
        logic        [30:0] rb;
    } t_m2;

    typedef struct packed {
        logic        [32:0] mx;
        logic        [32:0] my;
        logic               sx;
        logic               sy;
        logic signed [48:0] ax;
        logic signed [48:0] ay;
        logic        [30:0] ra;
        logic        [31:0] rsum;
    } t_m3;

    typedef struct packed {
        logic [65:0] sqx;
        logic [65:0] sqy;
        logic [63:0] rs2;
        t_m3         b;
    } t_m4;

    t_m1 r1, n1;
    t_m2 r2, n2;
    t_m3 r3, n3;
    t_m4 r4, n4;
    scc_pkg::t_sqs r5, n5;
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;

    logic signed [31:0] s_ts;
    logic signed [48:0] s_cx, s_cy;
    logic        [48:0] s_ux, s_uy;
    logic        [66:0] s_dsq;

    // stage 1: clamp quotient into [0, step], zero when not approaching
    always_comb begin
        priority if (!i_st.pos) begin
            n1.t = '0;
        end else if (i_st.ovf || (i_st.quo > {1'b0, i_st.dt})) begin
            n1.t = i_st.dt;
        end else begin
            n1.t = i_st.quo[30:0];
        end
        n1.dx  = i_st.dx;
        n1.dy  = i_st.dy;
        n1.rvx = i_st.rvx;
        n1.rvy = i_st.rvy;
        n1.pax = i_st.pax;
        n1.pay = i_st.pay;
        n1.vax = i_st.vax;
        n1.vay = i_st.vay;
        n1.ra  = i_st.ra;
        n1.rb  = i_st.rb;
    end

    // stage 2: velocity times time
    always_comb begin
        s_ts   = $signed({1'b0, r1.t});
        n2.prx = 65'(r1.rvx) * 65'(s_ts);
        n2.pry = 65'(r1.rvy) * 65'(s_ts);
        n2.pvx = 64'(r1.vax) * 64'(s_ts);
        n2.pvy = 64'(r1.vay) * 64'(s_ts);
        n2.dx  = r1.dx;
        n2.dy  = r1.dy;
        n2.pax = r1.pax;
        n2.pay = r1.pay;
        n2.ra  = r1.ra;
        n2.rb  = r1.rb;
    end

    // stage 3: closest separation and A's position; magnitudes clamp past any hit range
    always_comb begin
        s_cx    = 49'(r2.dx) + 49'(r2.prx >>> scc_pkg::FRAC_BITS);
        s_cy    = 49'(r2.dy) + 49'(r2.pry >>> scc_pkg::FRAC_BITS);
        s_ux    = s_cx[48] ? 49'(-s_cx) : 49'(s_cx);
        s_uy    = s_cy[48] ? 49'(-s_cy) : 49'(s_cy);
        n3.mx   = (|s_ux[48:33]) ? '1 : s_ux[32:0];
        n3.my   = (|s_uy[48:33]) ? '1 : s_uy[32:0];
        n3.sx   = s_cx[48];
        n3.sy   = s_cy[48];
        n3.ax   = 49'(r2.pax) + 49'(r2.pvx >>> scc_pkg::FRAC_BITS);
        n3.ay   = 49'(r2.pay) + 49'(r2.pvy >>> scc_pkg::FRAC_BITS);
        n3.ra   = r2.ra;
        n3.rsum = 32'(r2.ra) + 32'(r2.rb);
    end

    // stage 4: squares
    always_comb begin
        n4.sqx = 66'(r3.mx) * 66'(r3.mx);
        n4.sqy = 66'(r3.my) * 66'(r3.my);
        n4.rs2 = 64'(r3.rsum) * 64'(r3.rsum);
        n4.b   = r3;
    end

    // stage 5: squared distance and hit compare, square root setup
    always_comb begin
        s_dsq   = 67'(r4.sqx) + 67'(r4.sqy);
        n5.rad  = s_dsq[scc_pkg::SQ_IN-1:0];
        n5.rem  = '0;
        n5.root = '0;
        n5.hit  = {3'b000, r4.rs2} >= s_dsq;
        n5.mx   = r4.b.mx;
        n5.my   = r4.b.my;
        n5.sx   = r4.b.sx;
        n5.sy   = r4.b.sy;
        n5.ax   = r4.b.ax;
        n5.ay   = r4.b.ay;
        n5.ra   = r4.b.ra;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1 <= n1;
            r2 <= n2;
            r3 <= n3;
            r4 <= n4;
            r5 <= n5;
        end
    end

    assign o_vld = r5_vld;
    assign o_st  = r5;

endmodule

`default_nettype wire

@@ rtl/core/scc_sqrt.sv @@
// pipelined floor integer square root of the squared distance, one root bit per stage
// depends on scc_pkg
`default_nettype none

module scc_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire scc_pkg::t_sqs  i_st,
    output logic                o_vld,
    output scc_pkg::t_sqs       o_st
);

    // one digit-by-digit step: bring down two radicand bits, try (4*root+1)
    function automatic scc_pkg::t_sqs f_step(scc_pkg::t_sqs s);
        scc_pkg::t_sqs n;
        logic [35:0]   sh;
        logic [35:0]   tr;
        n  = s;
        sh = {s.rem[33:0], s.rad[scc_pkg::SQ_IN-1 -: 2]};
        tr = 36'({s.root, 2'b01});
        n.rad = {s.rad[scc_pkg::SQ_IN-3:0], 2'b00};
        if (sh >= tr) begin
            n.rem  = sh - tr;
            n.root = {s.root[scc_pkg::SQ_STEPS-2:0], 1'b1};
        end else begin
            n.rem  = sh;
            n.root = {s.root[scc_pkg::SQ_STEPS-2:0], 1'b0};
        end
        return n;
    endfunction

    scc_pkg::t_sqs r_st [scc_pkg::SQ_STEPS];
    logic [scc_pkg::SQ_STEPS-1:0] r_vld;

    for (genvar k = 0; k < scc_pkg::SQ_STEPS; k++) begin : g_stage
        scc_pkg::t_sqs n_st;
        logic          n_vld;

        if (k == 0) begin : g_first
            assign n_st  = f_step(i_st);
            assign n_vld = i_vld;
        end else begin : g_next
            assign n_st  = f_step(r_st[k-1]);
            assign n_vld = r_vld[k-1];
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_vld = r_vld[scc_pkg::SQ_STEPS-1];
    assign o_st  = r_st[scc_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/scc_odiv.sv @@
// offset along the contact normal: |c| * radius_a / distance for x and y,
// one product stage then a pipelined restoring divider; depends on scc_pkg
`default_nettype none

module scc_odiv (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_vld,
    input  wire scc_pkg::t_sqs  i_st,
    output logic                o_vld,
    output scc_pkg::t_odv       o_st
);

    // one restoring step on both coordinates
    function automatic scc_pkg::t_odv f_step(scc_pkg::t_odv s);
        scc_pkg::t_odv n;
        logic [32:0]   shx;
        logic [32:0]   shy;
        n   = s;
        shx = {s.remx, s.dvx[scc_pkg::OQ_BITS-1]};
        shy = {s.remy, s.dvy[scc_pkg::OQ_BITS-1]};
        n.dvx = {s.dvx[scc_pkg::OQ_BITS-2:0], 1'b0};
        n.dvy = {s.dvy[scc_pkg::OQ_BITS-2:0], 1'b0};
        if (shx >= {1'b0, s.span}) begin
            n.remx = 32'(shx - {1'b0, s.span});
            n.qx   = {s.qx[scc_pkg::OQ_BITS-2:0], 1'b1};
        end else begin
            n.remx = shx[31:0];
            n.qx   = {s.qx[scc_pkg::OQ_BITS-2:0], 1'b0};
        end
        if (shy >= {1'b0, s.span}) begin
            n.remy = 32'(shy - {1'b0, s.span});
            n.qy   = {s.qy[scc_pkg::OQ_BITS-2:0], 1'b1};
        end else begin
            n.remy = shy[31:0];
            n.qy   = {s.qy[scc_pkg::OQ_BITS-2:0], 1'b0};
        end
        return n;
    endfunction

    logic [63:0]   s_nx, s_ny;
    scc_pkg::t_odv n0, r0;
    logic          r0_vld;

    // product stage: dividends and divider setup
    always_comb begin
        s_nx    = 64'(i_st.mx) * 64'(i_st.ra);
        s_ny    = 64'(i_st.my) * 64'(i_st.ra);
        n0.span = i_st.root;
        n0.remx = s_nx[scc_pkg::OQ_BITS+31:scc_pkg::OQ_BITS];
        n0.remy = s_ny[scc_pkg::OQ_BITS+31:scc_pkg::OQ_BITS];
        n0.dvx  = s_nx[scc_pkg::OQ_BITS-1:0];
        n0.dvy  = s_ny[scc_pkg::OQ_BITS-1:0];
        n0.qx   = '0;
        n0.qy   = '0;
        n0.dz   = (i_st.root == '0);
        n0.hit  = i_st.hit;
        n0.sx   = i_st.sx;
        n0.sy   = i_st.sy;
        n0.ax   = i_st.ax;
        n0.ay   = i_st.ay;
        n0.ra   = i_st.ra;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0 <= n0;
        end
    end

    scc_pkg::t_odv r_st [scc_pkg::OQ_BITS];
    logic [scc_pkg::OQ_BITS-1:0] r_vld;

    for (genvar k = 0; k < scc_pkg::OQ_BITS; k++) begin : g_stage
        scc_pkg::t_odv n_st;
        logic          n_vld;

        if (k == 0) begin : g_first
            assign n_st  = f_step(r0);
            assign n_vld = r0_vld;
        end else begin : g_next
            assign n_st  = f_step(r_st[k-1]);
            assign n_vld = r_vld[k-1];
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_vld = r_vld[scc_pkg::OQ_BITS-1];
    assign o_st  = r_st[scc_pkg::OQ_BITS-1];

endmodule

`default_nettype wire

@@ rtl/core/swept_circle_collision_test_core.sv @@
// swept circle collision test: top level with pipeline control and output register
// depends on scc_pkg, scc_front, scc_tdiv, scc_mid, scc_sqrt, scc_odiv
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one candidate pair per beat
//   (positions, velocities, radii, time step, Q16.16). Output channel
//   o_out_valid / i_out_ready returns one beat per input: hit flag and the
//   saturated contact point, zero on a miss. Results leave in input order.
//   A beat passes from accept to o_out_valid through 4 front-end stages,
//   32 time divider stages, 5 approach and hit stages, 32 square root stages,
//   32 offset stages (product plus 31 divider steps) and the output register.
//   Throughput is one beat per cycle while i_out_ready does not hold the
//   output; each divider and the square root give one result bit per stage.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken. When the receiver holds i_out_ready low with a
//   result waiting, the pipeline freezes in place and o_in_ready drops;
//   nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; no beat is in flight
//   after reset and o_in_ready is high as soon as i_rst_n is released.
`default_nettype none

module swept_circle_collision_test_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire scc_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output scc_pkg::t_out      o_out_data
);

    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    logic          w_en;
    logic          w_fe_vld, w_td_vld, w_md_vld, w_sq_vld, w_od_vld;
    scc_pkg::t_tdv w_fe_st, w_td_st;
    scc_pkg::t_sqs w_md_st, w_sq_st;
    scc_pkg::t_odv w_od_st;

    logic          r_out_vld;
    scc_pkg::t_out r_out, n_out;

    logic signed [49:0] s_qx, s_qy, s_ox, s_oy, s_hx, s_hy;

    // whole pipeline moves when the output register can take a beat
    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en && i_rst_n;

    scc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_in    (i_in_data),
        .o_vld   (w_fe_vld),
        .o_st    (w_fe_st)
    );

    scc_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fe_vld),
        .i_st    (w_fe_st),
        .o_vld   (w_td_vld),
        .o_st    (w_td_st)
    );

    scc_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_td_vld),
        .i_st    (w_td_st),
        .o_vld   (w_md_vld),
        .o_st    (w_md_st)
    );

    scc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_md_vld),
        .i_st    (w_md_st),
        .o_vld   (w_sq_vld),
        .o_st    (w_sq_st)
    );

    scc_odiv u_odiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_st    (w_sq_st),
        .o_vld   (w_od_vld),
        .o_st    (w_od_st)
    );

    // contact point: signed offset, normal (1,0) at zero distance, saturate
    always_comb begin
        s_qx = 50'({1'b0, w_od_st.qx});
        s_qy = 50'({1'b0, w_od_st.qy});
        if (w_od_st.dz) begin
            s_ox = 50'({1'b0, w_od_st.ra});
            s_oy = '0;
        end else begin
            s_ox = w_od_st.sx ? -s_qx : s_qx;
            s_oy = w_od_st.sy ? -s_qy : s_qy;
        end
        s_hx = 50'(w_od_st.ax) + s_ox;
        s_hy = 50'(w_od_st.ay) + s_oy;
        n_out.hit = w_od_st.hit;
        priority if (!w_od_st.hit) begin
            n_out.hit_x = '0;
        end else if (s_hx > SAT_MAX) begin
            n_out.hit_x = SAT_MAX[31:0];
        end else if (s_hx < SAT_MIN) begin
            n_out.hit_x = SAT_MIN[31:0];
        end else begin
            n_out.hit_x = s_hx[31:0];
        end
        priority if (!w_od_st.hit) begin
            n_out.hit_y = '0;
        end else if (s_hy > SAT_MAX) begin
            n_out.hit_y = SAT_MAX[31:0];
        end else if (s_hy < SAT_MIN) begin
            n_out.hit_y = SAT_MIN[31:0];
        end else begin
            n_out.hit_y = s_hy[31:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_od_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a miss beat carries a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.hit_x == '0 && o_out_data.hit_y == '0))
        else $error("miss beat with nonzero contact point");

    // input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    // reset leaves the output empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
